// ===== rtl/lsb_stego_extract_caesar_core_defines.svh =====
// Assertion macros shared by the extractor RTL.
`ifndef LSB_STEGO_EXTRACT_CAESAR_CORE_DEFINES_SVH
`define LSB_STEGO_EXTRACT_CAESAR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LSBX_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lsbx assertion failed");

// Next-cycle implication, disabled during reset.
`define LSBX_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lsbx assertion failed");

`endif

// ===== rtl/lsbx_pkg.sv =====
// Shared types and constants of the LSB extractor with Caesar decryption.
package lsbx_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH + 1);

    localparam int CFG_COL_W   = 12;
    localparam int CFG_SHIFT_W = 5;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_COL     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LETTER_SHIFT  = 2'd2;

    localparam logic [7:0] ALPHABET_LEN = 8'd26;
    localparam logic [7:0] LOWER_A      = 8'h61;
    localparam logic [7:0] UPPER_A      = 8'h41;
    localparam logic [7:0] NUL_BYTE     = 8'h00;
    localparam logic [2:0] BITS_PER_PIX = 3'd3;

    typedef struct packed {
        logic [CFG_COL_W-1:0]   first_col;
        logic [CFG_COL_W-1:0]   column_stride;
        logic [CFG_SHIFT_W-1:0] letter_shift;
    } cfg_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       row_end;
        logic       image_start;
        logic       image_end;
    } pixel_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       byte_valid;
        logic       message_end;
    } result_t;

endpackage

// ===== rtl/lsbx_cfg.sv =====
// Configuration register file: start column, column stride, letter shift.
module lsbx_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lsbx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lsbx_pkg::CFG_COL_W-1:0] cfg_data,
    output lsbx_pkg::cfg_t                 cfg
);

    lsbx_pkg::cfg_t cfg_reg;
    lsbx_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                lsbx_pkg::REG_FIRST_COL:     cfg_next.first_col     = cfg_data;
                lsbx_pkg::REG_COLUMN_STRIDE: cfg_next.column_stride = cfg_data;
                lsbx_pkg::REG_LETTER_SHIFT:
                    cfg_next.letter_shift = cfg_data[lsbx_pkg::CFG_SHIFT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_col     <= '0;
            cfg_reg.column_stride <= lsbx_pkg::CFG_COL_W'(1);
            cfg_reg.letter_shift  <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/lsbx_caesar.sv =====
// Caesar decryption of one byte: letters shift back within their case.
module lsbx_caesar (
    input  logic [7:0]                       byte_in,
    input  logic [lsbx_pkg::CFG_SHIFT_W-1:0] shift,
    output logic [7:0]                       byte_out
);

    logic [7:0] s;
    logic [7:0] base;
    logic [7:0] idx;
    logic [7:0] t;
    logic       is_lower;
    logic       is_upper;

    always_comb begin
        s = 8'(shift);
        if (s >= lsbx_pkg::ALPHABET_LEN) begin
            s = s - lsbx_pkg::ALPHABET_LEN;
        end
        is_lower = (byte_in >= lsbx_pkg::LOWER_A) &&
                   (byte_in < lsbx_pkg::LOWER_A + lsbx_pkg::ALPHABET_LEN);
        is_upper = (byte_in >= lsbx_pkg::UPPER_A) &&
                   (byte_in < lsbx_pkg::UPPER_A + lsbx_pkg::ALPHABET_LEN);
        base = is_lower ? lsbx_pkg::LOWER_A : lsbx_pkg::UPPER_A;
        idx  = byte_in - base;
        t    = idx + lsbx_pkg::ALPHABET_LEN - s;
        if (t >= lsbx_pkg::ALPHABET_LEN) begin
            t = t - lsbx_pkg::ALPHABET_LEN;
        end
        byte_out = (is_lower || is_upper) ? (t + base) : byte_in;
    end

endmodule

// ===== rtl/lsbx_extract.sv =====
// Column sampling, bit accumulation and message state for one pixel per cycle while en is high.
`include "lsb_stego_extract_caesar_core_defines.svh"

module lsbx_extract (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  lsbx_pkg::pixel_t    pix,
    input  lsbx_pkg::cfg_t      cfg,
    output lsbx_pkg::result_t   res
);

    localparam logic [lsbx_pkg::COL_W-1:0] COL_MAX = lsbx_pkg::COL_W'(lsbx_pkg::MAX_WIDTH);

    logic [lsbx_pkg::COL_W-1:0] col_reg,  col_next;
    logic [lsbx_pkg::COL_W-1:0] samp_reg, samp_next;
    logic [7:0]                 acc_reg,  acc_next;
    logic [2:0]                 held_reg, held_next;
    logic                       done_reg, done_next;

    logic [lsbx_pkg::COL_W-1:0] col_c;
    logic [lsbx_pkg::COL_W-1:0] samp_c;
    logic [lsbx_pkg::COL_W-1:0] start_ext;
    logic [7:0]                 acc_c;
    logic [2:0]                 held_c;
    logic                       done_c;
    logic                       sampled;
    logic [2:0]                 pix_bits;
    logic [10:0]                joined;
    logic [1:0]                 rem;
    logic [7:0]                 full_byte;
    logic [7:0]                 plain_byte;
    logic [7:0]                 text;
    logic [lsbx_pkg::COL_W:0]   samp_sum;
    logic                       byte_valid;
    logic                       msg_end;

    lsbx_caesar u_caesar (
        .byte_in  (plain_byte),
        .shift    (cfg.letter_shift),
        .byte_out (text)
    );

    always_comb begin
        start_ext = lsbx_pkg::COL_W'(cfg.first_col);
        if (pix.image_start) begin
            col_c  = '0;
            samp_c = start_ext;
            acc_c  = '0;
            held_c = '0;
            done_c = 1'b0;
        end else begin
            col_c  = col_reg;
            samp_c = samp_reg;
            acc_c  = acc_reg;
            held_c = held_reg;
            done_c = done_reg;
        end

        sampled   = (col_c < COL_MAX) && (col_c == samp_c);
        pix_bits  = {pix.blue[0], pix.green[0], pix.red[0]};
        joined    = {acc_c, pix_bits};
        rem       = 2'(held_c - 3'd5);
        full_byte = 8'(joined >> rem);
        plain_byte = full_byte;

        acc_next   = acc_c;
        held_next  = held_c;
        done_next  = done_c;
        byte_valid = 1'b0;
        msg_end    = 1'b0;

        if (sampled && !done_c) begin
            if (held_c >= 3'd5) begin
                if (full_byte == lsbx_pkg::NUL_BYTE) begin
                    done_next = 1'b1;
                    msg_end   = 1'b1;
                    acc_next  = '0;
                    held_next = '0;
                end else begin
                    byte_valid = 1'b1;
                    acc_next   = 8'(pix_bits & ((3'd1 << rem) - 3'd1));
                    held_next  = 3'(rem);
                end
            end else begin
                acc_next  = joined[7:0];
                held_next = held_c + lsbx_pkg::BITS_PER_PIX;
            end
        end

        samp_sum  = {1'b0, samp_c} + (lsbx_pkg::COL_W + 1)'(cfg.column_stride);
        samp_next = samp_c;
        if (sampled) begin
            samp_next = (samp_sum > (lsbx_pkg::COL_W + 1)'(lsbx_pkg::MAX_WIDTH)) ?
                        COL_MAX : samp_sum[lsbx_pkg::COL_W-1:0];
        end

        col_next = col_c;
        if (pix.row_end || pix.image_end) begin
            col_next  = '0;
            samp_next = start_ext;
        end else if (col_c < COL_MAX) begin
            col_next = col_c + lsbx_pkg::COL_W'(1);
        end

        if (pix.image_end && !done_next) begin
            done_next = 1'b1;
            msg_end   = 1'b1;
            acc_next  = '0;
            held_next = '0;
        end
    end

    always_comb begin
        res.text_byte   = byte_valid ? text : 8'd0;
        res.byte_valid  = byte_valid;
        res.message_end = msg_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            samp_reg <= '0;
            acc_reg  <= '0;
            held_reg <= '0;
            done_reg <= 1'b0;
        end else if (en) begin
            col_reg  <= col_next;
            samp_reg <= samp_next;
            acc_reg  <= acc_next;
            held_reg <= held_next;
            done_reg <= done_next;
        end
    end

    `LSBX_ASSERT_NOW(a_done_clears_acc, aclk, aresetn, done_reg,
        (acc_reg == 8'd0) && (held_reg == 3'd0))
    `LSBX_ASSERT_NOW(a_quiet_after_end, aclk, aresetn, en && done_reg && !pix.image_start,
        !res.byte_valid && !res.message_end)
    `LSBX_ASSERT_NOW(a_col_in_range, aclk, aresetn, 1'b1,
        (col_reg <= COL_MAX) && (samp_reg <= COL_MAX))

endmodule

// ===== rtl/lsb_stego_extract_caesar_core.sv =====
// LSB steganography extractor with Caesar decryption, one pixel per clock while the output is not stalled.
//
// Pixel beats enter on the s_ channel in raster order: s_tdata holds blue,
// green, red; s_tlast marks the last pixel of a row; s_tuser carries the
// image start and image end flags. Each beat yields zero or one result beat
// on the m_ channel: a decrypted message byte (m_tuser high) and/or the end
// of the message (m_tlast high).
// Registers are written through the cfg_ channel (index 0 start column,
// 1 column stride, 2 letter shift); cfg_ready is always high.
// An accepted pixel is held in the input register, and its result beat is
// then captured in the output register. Throughput is one pixel per clock
// when not stalled, set by the single input register feeding the extract logic.
// When m_tready is low the result register holds; the input register still
// takes one more pixel, then s_tready drops until the result is taken.
// Synchronous active-low reset clears both pipeline valids, the registers
// to their defaults and the message state.
`include "lsb_stego_extract_caesar_core_defines.svh"

module lsb_stego_extract_caesar_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // blue, green, red
    input  logic                           s_tlast,   // row_end
    input  logic [1:0]                     s_tuser,   // image_start, image_end
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // text_byte
    output logic                           m_tlast,   // message_end
    output logic                           m_tuser,   // byte_valid
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lsbx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lsbx_pkg::CFG_COL_W-1:0] cfg_data
);

    lsbx_pkg::cfg_t    cfg;
    lsbx_pkg::pixel_t  pix_reg;
    lsbx_pkg::result_t res;
    lsbx_pkg::result_t out_reg;
    logic              in_valid_reg, in_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              advance;
    logic              s_accept;

    lsbx_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsbx_extract u_extract (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .pix     (pix_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (advance) begin
            out_valid_next = res.byte_valid || res.message_end;
        end else begin
            out_valid_next = out_valid_reg && !m_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pix_reg.blue        <= s_tdata[7:0];
            pix_reg.green       <= s_tdata[15:8];
            pix_reg.red         <= s_tdata[23:16];
            pix_reg.row_end     <= s_tlast;
            pix_reg.image_start <= s_tuser[0];
            pix_reg.image_end   <= s_tuser[1];
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.text_byte;
    assign m_tlast  = out_reg.message_end;
    assign m_tuser  = out_reg.byte_valid;

    `LSBX_ASSERT_NEXT(a_stalled_pixel_held, aclk, aresetn, in_valid_reg && !advance,
        in_valid_reg && $stable(pix_reg))
    `LSBX_ASSERT_NOW(a_result_has_content, aclk, aresetn, out_valid_reg,
        out_reg.byte_valid || out_reg.message_end)
    `LSBX_ASSERT_NOW(a_no_byte_zero_data, aclk, aresetn, out_valid_reg && !out_reg.byte_valid,
        out_reg.text_byte == 8'd0)

endmodule

// ===== tb/sv/lsb_stego_extract_caesar_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LSB extractor with Caesar decryption.
module lsb_stego_extract_caesar_core_tb;

    localparam int QUIET_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [23:0]                    s_tdata   = '0;
    logic                           s_tlast   = 1'b0;
    logic [1:0]                     s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [7:0]                     m_tdata;
    logic                           m_tlast;
    logic                           m_tuser;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [lsbx_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lsbx_pkg::CFG_COL_W-1:0] cfg_data  = '0;

    lsb_stego_extract_caesar_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    lsbx_pkg::pixel_t  pixel_q[$];
    lsbx_pkg::result_t pending_text[$];
    bit                msg_bits[$];

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    bit snk_hold      = 1'b0;
    bit px_taken      = 1'b0;
    int cfg_beats     = 0;
    int err_count     = 0;
    int quiet_cnt     = 0;

    // decoder copy: registers and per-image state
    logic [lsbx_pkg::CFG_COL_W-1:0]   p_start;
    logic [lsbx_pkg::CFG_COL_W-1:0]   p_stride;
    logic [lsbx_pkg::CFG_SHIFT_W-1:0] p_shift;
    logic [lsbx_pkg::COL_W-1:0]       p_col;
    logic [lsbx_pkg::COL_W-1:0]       p_next;
    logic [7:0]                       p_acc;
    logic [3:0]                       p_nbits;
    bit                               p_done;

    lsbx_pkg::pixel_t  seen_px;
    lsbx_pkg::result_t seen_beat;
    lsbx_pkg::result_t want;

    function automatic void reset_image();
        p_col   = '0;
        p_next  = lsbx_pkg::COL_W'(p_start);
        p_acc   = '0;
        p_nbits = '0;
        p_done  = 1'b0;
    endfunction

    function automatic logic [7:0] caesar_undo(logic [7:0] c);
        int s;
        int ci;
        int base;
        int alen;
        alen = int'(lsbx_pkg::ALPHABET_LEN);
        s    = int'(p_shift);
        if (s >= alen)
            s = s - alen;
        ci = int'(c);
        if (ci >= int'(lsbx_pkg::LOWER_A) && ci < int'(lsbx_pkg::LOWER_A) + alen) begin
            base = int'(lsbx_pkg::LOWER_A);
        end else if (ci >= int'(lsbx_pkg::UPPER_A) && ci < int'(lsbx_pkg::UPPER_A) + alen) begin
            base = int'(lsbx_pkg::UPPER_A);
        end else begin
            return c;
        end
        return 8'((ci - base + alen - s) % alen + base);
    endfunction

    function automatic bit decode_pixel(input lsbx_pkg::pixel_t px,
                                        output lsbx_pkg::result_t beat);
        logic [2:0]               lsb;
        logic [lsbx_pkg::COL_W:0] nxt;
        logic [7:0]               txt;
        bit                       sampled;
        bit                       valid;
        bit                       fin;
        lsb   = {px.blue[0], px.green[0], px.red[0]};
        txt   = '0;
        valid = 1'b0;
        fin   = 1'b0;
        if (px.image_start)
            reset_image();
        sampled = (p_col < lsbx_pkg::MAX_WIDTH) && (p_col == p_next);
        if (sampled && !p_done) begin
            for (int k = 2; k >= 0 && !p_done; k--) begin
                p_acc   = {p_acc[6:0], lsb[k]};
                p_nbits = p_nbits + 4'd1;
                if (p_nbits == 4'd8) begin
                    if (p_acc == lsbx_pkg::NUL_BYTE) begin
                        p_done = 1'b1;
                        fin    = 1'b1;
                    end else begin
                        txt   = caesar_undo(p_acc);
                        valid = 1'b1;
                    end
                    p_acc   = '0;
                    p_nbits = '0;
                end
            end
        end
        if (sampled) begin
            nxt    = {1'b0, p_next} + (lsbx_pkg::COL_W + 1)'(p_stride);
            p_next = (nxt > lsbx_pkg::MAX_WIDTH) ? lsbx_pkg::COL_W'(lsbx_pkg::MAX_WIDTH) :
                     nxt[lsbx_pkg::COL_W-1:0];
        end
        if (px.row_end || px.image_end) begin
            p_col  = '0;
            p_next = lsbx_pkg::COL_W'(p_start);
        end else if (p_col < lsbx_pkg::MAX_WIDTH) begin
            p_col = p_col + lsbx_pkg::COL_W'(1);
        end
        if (px.image_end && !p_done) begin
            p_done  = 1'b1;
            fin     = 1'b1;
            p_acc   = '0;
            p_nbits = '0;
        end
        beat.text_byte   = valid ? txt : 8'h00;
        beat.byte_valid  = valid;
        beat.message_end = fin;
        return valid || fin;
    endfunction

    task automatic report_error(string msg);
        err_count++;
        if (err_count <= 10)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    // monitor: predicts on input beats, checks output beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            p_start  = '0;
            p_stride = 12'd1;
            p_shift  = '0;
            reset_image();
            px_taken <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_text.size() == 0) begin
                    report_error($sformatf("unexpected beat text=%02h valid=%b end=%b",
                                           m_tdata, m_tuser, m_tlast));
                end else begin
                    want = pending_text.pop_front();
                    if (m_tdata !== want.text_byte || m_tuser !== want.byte_valid ||
                        m_tlast !== want.message_end)
                        report_error($sformatf(
                            "expected text=%02h valid=%b end=%b, got text=%02h valid=%b end=%b",
                            want.text_byte, want.byte_valid, want.message_end,
                            m_tdata, m_tuser, m_tlast));
                end
            end
            if (s_tvalid && s_tready) begin
                seen_px.blue        = s_tdata[7:0];
                seen_px.green       = s_tdata[15:8];
                seen_px.red         = s_tdata[23:16];
                seen_px.row_end     = s_tlast;
                seen_px.image_start = s_tuser[0];
                seen_px.image_end   = s_tuser[1];
                if (decode_pixel(seen_px, seen_beat))
                    pending_text.push_back(seen_beat);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    lsbx_pkg::REG_FIRST_COL:     p_start  = cfg_data;
                    lsbx_pkg::REG_COLUMN_STRIDE: p_stride = cfg_data;
                    lsbx_pkg::REG_LETTER_SHIFT:
                        p_shift = cfg_data[lsbx_pkg::CFG_SHIFT_W-1:0];
                    default: ;
                endcase
                cfg_beats <= cfg_beats + 1;
            end
            px_taken <= s_tvalid && s_tready;
        end
    end

    // pixel driver
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || px_taken)) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {pixel_q[0].red, pixel_q[0].green, pixel_q[0].blue};
                s_tlast  <= pixel_q[0].row_end;
                s_tuser  <= {pixel_q[0].image_end, pixel_q[0].image_start};
                void'(pixel_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk)
        m_tready <= aresetn && !snk_hold && ($urandom_range(99) >= snk_stall_pct);

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= WATCHDOG_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    function automatic void queue_text_byte(logic [7:0] ch);
        for (int i = 7; i >= 0; i--)
            msg_bits.push_back(ch[i]);
    endfunction

    // hidden bit stream, mostly letters so the decryption gets exercised
    function automatic bit next_lsb();
        int pick;
        if (msg_bits.size() == 0) begin
            pick = $urandom_range(99);
            if (pick < 55)
                queue_text_byte(8'(lsbx_pkg::LOWER_A + $urandom_range(0, 25)));
            else if (pick < 80)
                queue_text_byte(8'(lsbx_pkg::UPPER_A + $urandom_range(0, 25)));
            else if (pick < 98)
                queue_text_byte(8'($urandom_range(1, 255)));
            else
                queue_text_byte(lsbx_pkg::NUL_BYTE);
        end
        return msg_bits.pop_front();
    endfunction

    function automatic void push_pixel(bit row_end, bit img_start, bit img_end, bit full_swing);
        lsbx_pkg::pixel_t px;
        bit               b;
        b = next_lsb();
        px.blue = full_swing ? {8{b}} : {7'($urandom()), b};
        b = next_lsb();
        px.green = full_swing ? {8{b}} : {7'($urandom()), b};
        b = next_lsb();
        px.red = full_swing ? {8{b}} : {7'($urandom()), b};
        px.row_end     = row_end;
        px.image_start = img_start;
        px.image_end   = img_end;
        pixel_q.push_back(px);
    endfunction

    // mostly well-formed images, some with missing marks, some raw noise
    task automatic push_random(int n_items, int max_w);
        int  sent;
        int  rows;
        int  width;
        bit  miss_start;
        bit  miss_end;
        bit  bare_end;
        bit  last;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 10) begin
                repeat ($urandom_range(1, 6)) begin
                    pixel_q.push_back(lsbx_pkg::pixel_t'($urandom()));
                    sent++;
                end
            end else begin
                rows       = $urandom_range(1, 3);
                width      = $urandom_range(1, max_w);
                miss_start = ($urandom_range(9) == 0);
                miss_end   = ($urandom_range(9) == 0);
                bare_end   = ($urandom_range(3) == 0);
                for (int r = 0; r < rows; r++) begin
                    for (int c = 0; c < width; c++) begin
                        last = (r == rows - 1) && (c == width - 1);
                        push_pixel(c == width - 1 && !(last && bare_end),
                                   r == 0 && c == 0 && !miss_start,
                                   last && !miss_end, 1'b0);
                        sent++;
                    end
                end
            end
        end
    endtask

    task automatic write_reg(logic [lsbx_pkg::CFG_IDX_W-1:0] idx,
                             logic [lsbx_pkg::CFG_COL_W-1:0] val);
        int seen;
        seen = cfg_beats;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        wait (cfg_beats != seen);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic [lsbx_pkg::CFG_COL_W-1:0] start,
                            logic [lsbx_pkg::CFG_COL_W-1:0] stride,
                            logic [lsbx_pkg::CFG_COL_W-1:0] shift);
        write_reg(lsbx_pkg::REG_FIRST_COL, start);
        write_reg(lsbx_pkg::REG_COLUMN_STRIDE, stride);
        write_reg(lsbx_pkg::REG_LETTER_SHIFT, shift);
    endtask

    task automatic settle();
        wait (pixel_q.size() == 0 && !s_tvalid);
        wait (pending_text.size() == 0);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // letter boundaries before any image start, zero byte mid-pixel
        set_regs(12'd0, 12'd1, 12'd3);
        queue_text_byte("a");
        queue_text_byte("z");
        queue_text_byte("A");
        queue_text_byte("Z");
        queue_text_byte("@");
        queue_text_byte("[");
        queue_text_byte("{");
        queue_text_byte(lsbx_pkg::NUL_BYTE);
        for (int i = 0; i < 22; i++)
            push_pixel(i == 11 || i == 21, 1'b0, 1'b0, 1'b1);
        push_pixel(1'b0, 1'b0, 1'b1, 1'b1);
        settle();
        // last pixel completes a byte; then a partial byte cut by image end
        msg_bits.delete();
        queue_text_byte("H");
        queue_text_byte("i");
        queue_text_byte("!");
        for (int i = 0; i < 8; i++)
            push_pixel(1'b0, i == 0, i == 7, 1'b0);
        push_pixel(1'b0, 1'b1, 1'b0, 1'b1);
        push_pixel(1'b1, 1'b0, 1'b1, 1'b1);
        settle();

        set_regs(12'd0, 12'd1, 12'd25);
        push_random(60, 24);
        settle();

        src_idle_pct = 68;
        set_regs(12'($urandom_range(0, 5)), 12'($urandom_range(1, 3)),
                 {7'($urandom_range(0, 127)), 5'(26 + $urandom_range(0, 5))});
        push_random(60, 24);
        settle();

        src_idle_pct  = 0;
        snk_stall_pct = 68;
        set_regs(12'd0, 12'd1, 12'($urandom_range(1, 24)));
        push_random(35, 24);
        settle();
        push_random(35, 24);
        settle();

        src_idle_pct  = 35;
        snk_stall_pct = 35;
        set_regs(12'($urandom_range(0, 3)), 12'd0, 12'd0);
        push_random(50, 16);
        settle();

        // receiver held off while the sender keeps offering
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        set_regs(12'd0, 12'd1, 12'($urandom_range(0, 25)));
        fork
            begin
                snk_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                snk_hold = 1'b0;
            end
        join_none
        push_random(70, 24);
        settle();

        // widest stride: one sample per row, sample pointer may saturate
        set_regs(12'($urandom_range(0, 3)), 12'd4095, 12'hFFF);
        push_random(40, 8);
        settle();

        src_idle_pct  = 35;
        snk_stall_pct = 35;
        set_regs(12'($urandom_range(0, 2)), 12'($urandom_range(1, 2)),
                 12'($urandom_range(0, 31)));
        push_random(40, 24);
        settle();

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
